### sv/pmsd_pkg.sv
// ----------------------------------------------------------------------------
// pmsd_pkg
// Shared constants, types and helper functions of the segment-decay peak meter.
// ----------------------------------------------------------------------------
package pmsd_pkg;

  localparam int METER_COUNT      = 8;
  localparam int SEGMENT_COUNT    = 32;
  localparam int GROUP_COUNT      = 8;
  localparam int LANE_COUNT       = 4;
  localparam int ROW_COUNT        = METER_COUNT * GROUP_COUNT;
  localparam int ROW_W            = $clog2(ROW_COUNT);
  localparam int GROUP_W          = $clog2(GROUP_COUNT);
  localparam int FULL_SCALE       = 32768;
  localparam int HALF_LIFE_FRAMES = 12;
  localparam int FADE_TABLE_DEPTH = 128;
  localparam int FADE_IDX_W       = $clog2(FADE_TABLE_DEPTH);
  localparam int MAG_W            = 17;
  localparam logic [7:0] BRIGHT_MAX = 8'd255;

  typedef logic [LANE_COUNT-1:0][7:0] row_t;
  typedef logic [FADE_TABLE_DEPTH-1:0][15:0] fade_table_t;

  // Store access for one cycle: one read port, one write port.
  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    row_t             wr_data;
  } store_req_t;

  // Per-item decay control, latched when the update beat is taken.
  typedef struct packed {
    logic        update;
    logic        unity;
    logic [15:0] factor;
  } decay_ctl_t;

  // (p * y) >> 32 applied n times, starting from 1.0 in Q0.32
  function automatic logic [63:0] q32_power(logic [63:0] y, int n);
    logic [63:0] p;
    p = 64'd1 << 32;
    for (int i = 0; i < n; i++) begin
      p = (p * y) >> 32;
    end
    return p;
  endfunction

  // Q0.16 fade factors 0.5^(d/HALF_LIFE_FRAMES), built at elaboration
  function automatic fade_table_t build_fade_table();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] y;
    logic [63:0] p;
    logic [63:0] e;
    fade_table_t t;
    lo = 64'd0;
    hi = 64'hFFFF_FFFF;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      if (q32_power(mid, HALF_LIFE_FRAMES) >= (64'd1 << 31)) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    y    = lo;
    t[0] = 16'hFFFF;
    p    = 64'd1 << 32;
    for (int d = 1; d < FADE_TABLE_DEPTH; d++) begin
      p    = (p * y) >> 32;
      e    = (p + 64'd32768) >> 16;
      t[d] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
    end
    return t;
  endfunction

  localparam fade_table_t FADE_TABLE = build_fade_table();

  // |peak| clamped to full scale; -32768 gives 32768
  function automatic logic [MAG_W-1:0] peak_mag(logic [15:0] v);
    logic [MAG_W-1:0] m;
    m = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    return (m > MAG_W'(FULL_SCALE)) ? MAG_W'(FULL_SCALE) : m;
  endfunction

  // threshold of segment s: floor((s+1) * FULL_SCALE / SEGMENT_COUNT)
  function automatic logic [MAG_W-1:0] seg_threshold(logic [GROUP_W+1:0] s);
    return MAG_W'(((int'(s) + 1) * FULL_SCALE) / SEGMENT_COUNT);
  endfunction

endpackage

### sv/pmsd_in_if.sv
// ----------------------------------------------------------------------------
// pmsd_in_if
// Update/clear channel: valid/ready handshake with frame number and peaks.
// ----------------------------------------------------------------------------
interface pmsd_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [31:0]        frame_no;
  logic signed [15:0] peak_fm_left;
  logic signed [15:0] peak_fm_right;
  logic signed [15:0] peak_psg_left;
  logic signed [15:0] peak_psg_right;
  logic signed [15:0] peak_dac_left;
  logic signed [15:0] peak_dac_right;
  logic signed [15:0] peak_mix_left;
  logic signed [15:0] peak_mix_right;

  modport source (
    output valid, mode, frame_no, peak_fm_left, peak_fm_right, peak_psg_left,
           peak_psg_right, peak_dac_left, peak_dac_right, peak_mix_left,
           peak_mix_right,
    input  ready
  );

  modport sink (
    input  valid, mode, frame_no, peak_fm_left, peak_fm_right, peak_psg_left,
           peak_psg_right, peak_dac_left, peak_dac_right, peak_mix_left,
           peak_mix_right,
    output ready
  );
endinterface

### sv/pmsd_out_if.sv
// ----------------------------------------------------------------------------
// pmsd_out_if
// Result channel: one beat per group of four segments.
// ----------------------------------------------------------------------------
interface pmsd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] meter_index;
  logic [2:0] segment_group;
  logic [7:0] brightness_a;
  logic [7:0] brightness_b;
  logic [7:0] brightness_c;
  logic [7:0] brightness_d;
  logic [3:0] lit_bits;
  logic       last;

  modport source (
    output valid, meter_index, segment_group, brightness_a, brightness_b,
           brightness_c, brightness_d, lit_bits, last,
    input  ready
  );

  modport sink (
    input  valid, meter_index, segment_group, brightness_a, brightness_b,
           brightness_c, brightness_d, lit_bits, last,
    output ready
  );
endinterface

### sv/pmsd_store.sv
// ----------------------------------------------------------------------------
// pmsd_store
// Brightness store: one row of four segments per entry, registered read,
// per-row valid bits so that reset and clear read back as zero at once.
// ----------------------------------------------------------------------------
module pmsd_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  pmsd_pkg::store_req_t req_i,
  output pmsd_pkg::row_t       rd_data_o
);
  import pmsd_pkg::*;

  row_t                 mem_q [ROW_COUNT];
  row_t                 rd_data_q;
  logic                 rd_valid_q;
  logic [ROW_COUNT-1:0] row_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (clear_i) begin
        row_valid_q <= '0;
      end else if (req_i.wr_en) begin
        row_valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= row_valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

### sv/pmsd_decay.sv
// ----------------------------------------------------------------------------
// pmsd_decay
// Next brightness of one row: on an update, lit segments go full, others fade
// by the Q0.16 factor (held at unity) with rounding and a forced step of one.
// ----------------------------------------------------------------------------
module pmsd_decay (
  input  pmsd_pkg::row_t       cur_i,
  input  logic [3:0]           lit_i,
  input  pmsd_pkg::decay_ctl_t ctl_i,
  output pmsd_pkg::row_t       next_o
);
  import pmsd_pkg::*;

  always_comb begin
    logic [24:0] prod;
    logic [8:0]  faded;
    for (int i = 0; i < LANE_COUNT; i++) begin
      prod  = 25'(cur_i[i]) * 25'(ctl_i.factor) + 25'd32768;
      faded = prod[24:16];
      next_o[i] = cur_i[i];
      if (ctl_i.update) begin
        if (lit_i[i]) begin
          next_o[i] = BRIGHT_MAX;
        end else if (cur_i[i] != 8'd0 && !ctl_i.unity) begin
          // no drop after rounding: force one step down
          next_o[i] = (faded >= {1'b0, cur_i[i]}) ? cur_i[i] - 8'd1 : faded[7:0];
        end
      end
    end
  end

endmodule

### sv/peak_meter_segment_decay.sv
// ----------------------------------------------------------------------------
// peak_meter_segment_decay
// Eight 32-segment bar meters with trail brightness that fades with frame
// distance; every update reports all segments, four per result beat.
// ----------------------------------------------------------------------------
//
//   channel  dir  beat                                       handshake
//   in_i     in   mode, frame_no, eight signed 16-bit peaks  valid/ready
//   out_o    out  meter, group, 4 x brightness, lit, last    valid/ready
//
// An update beat is followed by 64 result beats, one per row: ST_ISSUE reads
// the row from the store (registered read), then ST_WRITE folds the decay into
// it, writes it back on a new frame and loads the output register. A clear
// beat gives no result.
// Reset clears the per-row valid bits at once; there is no sweep.
// Output backpressure holds the sequencer on its current row; a new input
// beat is taken while the final result still sits in the output register.
// ----------------------------------------------------------------------------
module peak_meter_segment_decay (
  input  logic      clk_i,
  input  logic      rst_ni,
  pmsd_in_if.sink   in_i,
  pmsd_out_if.source out_o
);
  import pmsd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WRITE
  } state_e;

  state_e           state_q;
  logic [ROW_W-1:0] row_q;
  logic [15:0]      peaks_q [METER_COUNT];
  logic [31:0]      fade_frame_q;
  logic             fade_valid_q;
  logic [31:0]      seen_frame_q;
  logic             seen_valid_q;
  decay_ctl_t       ctl_q;

  // output register
  logic             out_valid_q;
  logic [2:0]       out_meter_q;
  logic [2:0]       out_group_q;
  row_t             out_bright_q;
  logic [3:0]       out_lit_q;
  logic             out_last_q;

  logic             in_take;
  logic             out_free;
  logic             row_load;
  logic             row_last;
  logic             clear_store;
  store_req_t       store_req;
  row_t             cur_row;
  row_t             next_row;
  logic [3:0]       lit;
  logic [MAG_W-1:0] mag;
  logic [31:0]      delta;
  logic [FADE_IDX_W-1:0] fade_idx;
  logic             new_update;
  logic             new_unity;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_take     = in_i.valid && in_i.ready;
  assign clear_store = in_take && in_i.mode;
  assign out_free    = !out_valid_q || out_o.ready;
  assign row_load    = (state_q == ST_WRITE) && out_free;
  assign row_last    = (row_q == ROW_W'(ROW_COUNT - 1));

  // frame bookkeeping for the incoming beat
  assign new_update = !seen_valid_q || (in_i.frame_no != seen_frame_q);
  assign new_unity  = !fade_valid_q || (in_i.frame_no <= fade_frame_q);
  assign delta      = in_i.frame_no - fade_frame_q;
  assign fade_idx   = (delta >= 32'(FADE_TABLE_DEPTH)) ?
                      FADE_IDX_W'(FADE_TABLE_DEPTH - 1) : delta[FADE_IDX_W-1:0];

  // lit bits of the row being worked: meter in the upper row bits
  assign mag = peak_mag(peaks_q[row_q[ROW_W-1:GROUP_W]]);
  always_comb begin
    for (int i = 0; i < LANE_COUNT; i++) begin
      lit[i] = (mag >= seg_threshold({row_q[GROUP_W-1:0], 2'(i)}));
    end
  end

  always_comb begin
    store_req         = '0;
    store_req.rd_en   = (state_q == ST_ISSUE);
    store_req.rd_addr = row_q;
    store_req.wr_en   = row_load && ctl_q.update;
    store_req.wr_addr = row_q;
    store_req.wr_data = next_row;
  end

  pmsd_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (clear_store),
    .req_i     (store_req),
    .rd_data_o (cur_row)
  );

  pmsd_decay u_decay (
    .cur_i  (cur_row),
    .lit_i  (lit),
    .ctl_i  (ctl_q),
    .next_o (next_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      row_q        <= '0;
      fade_frame_q <= '0;
      fade_valid_q <= 1'b0;
      seen_frame_q <= '0;
      seen_valid_q <= 1'b0;
      ctl_q        <= '0;
      out_valid_q  <= 1'b0;
      out_meter_q  <= '0;
      out_group_q  <= '0;
      out_bright_q <= '0;
      out_lit_q    <= '0;
      out_last_q   <= 1'b0;
      for (int m = 0; m < METER_COUNT; m++) begin
        peaks_q[m] <= '0;
      end
    end else begin
      if (out_o.ready && !row_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            if (in_i.mode) begin
              fade_frame_q <= '0;
              fade_valid_q <= 1'b0;
              seen_frame_q <= '0;
              seen_valid_q <= 1'b0;
            end else begin
              peaks_q[0]   <= in_i.peak_fm_left;
              peaks_q[1]   <= in_i.peak_fm_right;
              peaks_q[2]   <= in_i.peak_psg_left;
              peaks_q[3]   <= in_i.peak_psg_right;
              peaks_q[4]   <= in_i.peak_dac_left;
              peaks_q[5]   <= in_i.peak_dac_right;
              peaks_q[6]   <= in_i.peak_mix_left;
              peaks_q[7]   <= in_i.peak_mix_right;
              ctl_q.update <= new_update;
              ctl_q.unity  <= new_unity;
              ctl_q.factor <= FADE_TABLE[fade_idx];
              if (new_update) begin
                fade_frame_q <= in_i.frame_no;
                fade_valid_q <= 1'b1;
              end
              seen_frame_q <= in_i.frame_no;
              seen_valid_q <= 1'b1;
              row_q        <= '0;
              state_q      <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          if (row_load) begin
            out_valid_q  <= 1'b1;
            out_meter_q  <= row_q[ROW_W-1:GROUP_W];
            out_group_q  <= row_q[GROUP_W-1:0];
            out_bright_q <= next_row;
            out_lit_q    <= lit;
            out_last_q   <= row_last;
            if (row_last) begin
              state_q <= ST_IDLE;
            end else begin
              row_q   <= row_q + ROW_W'(1);
              state_q <= ST_ISSUE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.meter_index   = out_meter_q;
  assign out_o.segment_group = out_group_q;
  assign out_o.brightness_a  = out_bright_q[0];
  assign out_o.brightness_b  = out_bright_q[1];
  assign out_o.brightness_c  = out_bright_q[2];
  assign out_o.brightness_d  = out_bright_q[3];
  assign out_o.lit_bits      = out_lit_q;
  assign out_o.last          = out_last_q;

  // store writes only come from the write-back step
  a_wr_in_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req.wr_en |-> (state_q == ST_WRITE))
    else $error("store write outside write-back step");

  // the final row's beat returns the sequencer to idle, flagged last
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_load && row_last) |=> (state_q == ST_IDLE) && out_valid_q && out_last_q)
    else $error("final row did not end the update");

  // an update beat starts at row zero
  a_start_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && !in_i.mode) |=> (state_q == ST_ISSUE) && (row_q == '0))
    else $error("update did not start at row zero");

  // a clear beat drops the frame history
  a_clear_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && in_i.mode) |=> !seen_valid_q && !fade_valid_q && (state_q == ST_IDLE))
    else $error("clear left frame history");

endmodule
